### rtl/dmsm_pkg.sv
// Shared types, constants and helpers for the door motion state machine.
// Used by every module of the block; no dependencies of its own.
package dmsm_pkg;

  localparam int GYRO_WIDTH = 16;
  localparam int SUM_WIDTH  = GYRO_WIDTH + 2;
  localparam int THR_WIDTH  = 17;
  localparam int CFG_IDX_W  = 2;

  // Door modes.
  localparam logic [2:0] MODE_STARTUP = 3'd0;
  localparam logic [2:0] MODE_UNKNOWN = 3'd1;
  localparam logic [2:0] MODE_OPEN    = 3'd2;
  localparam logic [2:0] MODE_CLOSED  = 3'd3;
  localparam logic [2:0] MODE_PAUSED  = 3'd4;
  localparam logic [2:0] MODE_OPENING = 3'd5;
  localparam logic [2:0] MODE_CLOSING = 3'd6;

  // Commands.
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_OPEN    = 3'd1;
  localparam logic [2:0] CMD_CLOSE   = 3'd2;
  localparam logic [2:0] CMD_REFRESH = 3'd3;
  localparam logic [2:0] CMD_PAUSE   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TICKS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_SPEED      = 2'd2;

  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET   = 17'd96;
  localparam logic [7:0]           STOP_TICKS_RESET  = 8'd10;
  localparam logic [7:0]           MOTOR_SPEED_RESET = 8'd255;
  localparam logic [7:0]           QUIET_MAX         = 8'd255;

  typedef struct packed {
    logic [2:0]                   command;
    logic                         gyro_valid;
    logic signed [GYRO_WIDTH-1:0] gyro_x;
    logic signed [GYRO_WIDTH-1:0] gyro_y;
    logic signed [GYRO_WIDTH-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode_code;
    logic       mode_changed;
    logic       motor_run;
    logic       motor_dir;
    logic [7:0] drive_speed;
    logic       refresh_report;
    logic [7:0] report_speed;
  } out_item_t;

  // A tick after the front stage: command plus the summed rate magnitude.
  typedef struct packed {
    logic [2:0]           command;
    logic                 gyro_valid;
    logic [SUM_WIDTH-1:0] rate_sum;
  } tick_t;

  typedef struct packed {
    logic [THR_WIDTH-1:0] motion_threshold;
    logic [7:0]           stop_ticks;
    logic [7:0]           motor_speed;
  } cfg_t;

  // The most negative rate yields 2^(GYRO_WIDTH-1), which still fits unsigned.
  function automatic logic [GYRO_WIDTH-1:0] rate_mag(input logic [GYRO_WIDTH-1:0] r);
    logic [GYRO_WIDTH-1:0] neg;
    neg = ~r + 1'b1;
    return r[GYRO_WIDTH-1] ? neg : r;
  endfunction

endpackage

### rtl/dmsm_cfg.sv
// Configuration register bank of the door motion state machine.
// Depends on dmsm_pkg for register indexes, reset values and cfg_t.
module dmsm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dmsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmsm_pkg::THR_WIDTH-1:0]  cfg_data,
  output dmsm_pkg::cfg_t                  cfg
);
  import dmsm_pkg::*;

  assign cfg_ready = 1'b1;

  // Writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motion_threshold <= THRESHOLD_RESET;
      cfg.stop_ticks       <= STOP_TICKS_RESET;
      cfg.motor_speed      <= MOTOR_SPEED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MOTION_THRESHOLD: cfg.motion_threshold <= cfg_data;
        REG_STOP_TICKS:       cfg.stop_ticks       <= cfg_data[7:0];
        REG_MOTOR_SPEED:      cfg.motor_speed      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/dmsm_front.sv
// Input stage: registers each accepted tick with its summed rate magnitude.
// Depends on dmsm_pkg for in_item_t, tick_t and rate_mag.
module dmsm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dmsm_pkg::in_item_t in_data,
  output logic               tick_valid,
  output dmsm_pkg::tick_t    tick,
  input  logic               tick_take
);
  import dmsm_pkg::*;

  logic [SUM_WIDTH-1:0] sum_next;

  assign in_ready = !tick_valid || tick_take;

  always_comb begin
    sum_next = {2'b00, rate_mag(in_data.gyro_x)}
             + {2'b00, rate_mag(in_data.gyro_y)}
             + {2'b00, rate_mag(in_data.gyro_z)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick.command    <= in_data.command;
      tick.gyro_valid <= in_data.gyro_valid;
      tick.rate_sum   <= sum_next;
    end
  end

endmodule

### rtl/dmsm_core.sv
// Mode state machine and result register of the door motion state machine.
// Depends on dmsm_pkg for modes, commands, tick_t, cfg_t and out_item_t.
module dmsm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  input  dmsm_pkg::tick_t     tick,
  output logic                tick_take,
  input  dmsm_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output dmsm_pkg::out_item_t out_data
);
  import dmsm_pkg::*;

  logic [2:0]  door_mode;
  logic [2:0]  door_mode_next;
  logic [7:0]  quiet_count;
  logic [7:0]  quiet_count_next;
  logic        refresh;
  logic        moving_now;
  logic        moving_next;
  logic        active;
  out_item_t   result_next;

  assign tick_take = tick_valid && (!out_valid || out_ready);

  assign moving_now = (door_mode == MODE_OPENING) || (door_mode == MODE_CLOSING);
  assign active     = tick.gyro_valid && (tick.rate_sum > {1'b0, cfg.motion_threshold});

  always_comb begin
    door_mode_next   = door_mode;
    quiet_count_next = quiet_count;
    refresh          = 1'b0;
    if (door_mode == MODE_STARTUP) begin
      door_mode_next = MODE_UNKNOWN;
    end else begin
      case (tick.command)
        CMD_OPEN: begin
          door_mode_next = MODE_OPENING;
          if (door_mode != MODE_OPENING) quiet_count_next = '0;
        end
        CMD_CLOSE: begin
          door_mode_next = MODE_CLOSING;
          if (door_mode != MODE_CLOSING) quiet_count_next = '0;
        end
        CMD_PAUSE: begin
          door_mode_next = MODE_PAUSED;
        end
        default: begin
          // No mode selected: refresh, none, or an unused code.
          refresh = (tick.command == CMD_REFRESH);
          if (moving_now) begin
            if (active) begin
              quiet_count_next = '0;
            end else if (quiet_count != QUIET_MAX) begin
              quiet_count_next = quiet_count + 8'd1;
            end
            if (quiet_count_next > cfg.stop_ticks) begin
              door_mode_next = (door_mode == MODE_OPENING) ? MODE_OPEN : MODE_CLOSED;
            end
          end
        end
      endcase
    end
  end

  assign moving_next = (door_mode_next == MODE_OPENING) || (door_mode_next == MODE_CLOSING);

  always_comb begin
    result_next.mode_code      = door_mode_next;
    result_next.mode_changed   = (door_mode_next != door_mode);
    result_next.motor_run      = moving_next;
    result_next.motor_dir      = (door_mode_next == MODE_CLOSING);
    result_next.drive_speed    = moving_next ? cfg.motor_speed : 8'd0;
    result_next.refresh_report = refresh;
    result_next.report_speed   = refresh ? cfg.motor_speed : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      door_mode   <= MODE_STARTUP;
      quiet_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (tick_take) begin
        door_mode   <= door_mode_next;
        quiet_count <= quiet_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      out_data <= result_next;
    end
  end

endmodule

### rtl/door_motion_state_machine_unit.sv
// Top level of the door motion state machine: config bank, input stage, core.
// Depends on dmsm_pkg, dmsm_cfg, dmsm_front and dmsm_core.
//
//   Channel | Signals                                    | Beat taken when
//   --------+--------------------------------------------+---------------------
//   in      | in_valid, in_ready, in_data (in_item_t)    | in_valid && in_ready
//   out     | out_valid, out_ready, out_data (out_item_t)| out_valid && out_ready
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid && cfg_ready
//
// One tick is accepted per cycle while the result side does not stall; its
// result passes through the input register and then the result register.
// Synchronous reset returns the mode to startup, clears the quiet count and
// restores the register defaults; no clearing pass is needed.
// While the result register is stalled, one more tick is held in the input
// register and in_ready drops until the result beat is taken.
module door_motion_state_machine_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dmsm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dmsm_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmsm_pkg::THR_WIDTH-1:0] cfg_data
);
  import dmsm_pkg::*;

  cfg_t  cfg;
  tick_t tick;
  logic  tick_valid;
  logic  tick_take;

  dmsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take)
  );

  dmsm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### rtl/dmsm_checker.sv
// Port-level checks for the door motion state machine, bound to the top level.
// Depends on dmsm_pkg and door_motion_state_machine_unit.
module dmsm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dmsm_pkg::out_item_t out_data
);
  import dmsm_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The motor runs exactly in the moving modes, and only closing drives direction.
  a_motor_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.motor_run ==
                   ((out_data.mode_code == MODE_OPENING) ||
                    (out_data.mode_code == MODE_CLOSING))) &&
                  (out_data.motor_dir == (out_data.mode_code == MODE_CLOSING)))
    else $error("motor outputs disagree with mode");

  // Speeds are zero unless running or reporting.
  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.motor_run || out_data.drive_speed == 8'd0) &&
                  (out_data.refresh_report || out_data.report_speed == 8'd0))
    else $error("speed reported outside its mode");

  // Input is refused only while a result beat is waiting on the output.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with the result side free");

  // No result beat is offered in the first cycle after reset.
  a_first_tick: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind door_motion_state_machine_unit dmsm_checker u_dmsm_checker (.*);
